// ===== src/lrbc_pkg.sv =====
package lrbc_pkg;

   localparam int COORD_W  = 32;
   localparam int SIZE_W   = 31;
   localparam int LEVEL_W  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int LEVEL_MAX = 15;

   // bound, gap, square and distance widths
   localparam int BOUND_W = COORD_W + 2;
   localparam int GAP_W   = COORD_W;
   localparam int SQ_W    = 2 * GAP_W;
   localparam int DIST_W  = SQ_W + 2;
   localparam int VSQ_W   = 2 * SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FOCUS_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCUS_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCUS_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOXEL_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT = 3'd4;

   localparam logic [SIZE_W-1:0]  VOXEL_SIZE_RESET  = 31'd6400;
   localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 4'd8;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef logic [GAP_W-1:0]          gap_type;
   typedef logic [SQ_W-1:0]           sq_type;

endpackage

// ===== src/lod_ring_box_classifier.sv =====
// Detail-ring selector for one axis-aligned cube.
//
// Input channel req_*: one word per cube (center_x/y/z, half_size, signed
// and unsigned Q23.8). Result channel rsp_*: one word per cube, rsp_level,
// the first detail ring that reaches the cube, or the level count if none.
// Config port csr_*: csr_write, csr_index, csr_data; write only while no
// word is in flight.
//
// One word is accepted every cycle unless the pipeline holds: six register
// stages (bounds, clamp gap, squares, sums, ring compares, priority encode)
// each move one word per cycle, and rsp_valid is the last stage's valid.
//
// Reset clears all stage valids and loads the config registers with their reset
// values (focus at origin, voxel_size 6400, level_count 8).
//
// While rsp_valid is high and rsp_stall is high the whole pipeline holds
// and req_stall is raised; bubbles inside the pipeline are kept.
module lod_ring_box_classifier #(
   parameter int LEVEL_LIMIT = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_write,
   input  logic [lrbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lrbc_pkg::CSR_DATA_W-1:0]      csr_data,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [lrbc_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [lrbc_pkg::COORD_W-1:0]  req_center_y,
   input  logic signed [lrbc_pkg::COORD_W-1:0]  req_center_z,
   input  logic [lrbc_pkg::SIZE_W-1:0]          req_half_size,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lrbc_pkg::LEVEL_W-1:0]         rsp_level
);

   localparam int LANES = (LEVEL_LIMIT < lrbc_pkg::LEVEL_MAX) ?
                          LEVEL_LIMIT : lrbc_pkg::LEVEL_MAX;
   localparam int R2_W  = lrbc_pkg::DIST_W + 2 * (LANES - 2);

   // config registers
   lrbc_pkg::coord_type                 focus_ff [3];
   logic [lrbc_pkg::SIZE_W-1:0]         voxel_size_ff;
   logic [lrbc_pkg::LEVEL_W-1:0]        level_count_ff;

   // pipeline
   logic                                advance;
   logic                                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   lrbc_pkg::coord_type                 center [3];
   lrbc_pkg::bound_type                 lo_in [3];
   lrbc_pkg::bound_type                 hi_in [3];
   lrbc_pkg::bound_type                 lo_ff [3];
   lrbc_pkg::bound_type                 hi_ff [3];
   lrbc_pkg::gap_type                   gap_in [3];
   lrbc_pkg::gap_type                   gap_ff [3];
   lrbc_pkg::sq_type                    sq_ff [3];
   logic [lrbc_pkg::VSQ_W-1:0]          vsq_ff;
   logic [lrbc_pkg::DIST_W-1:0]         dist_in, dist_ff;
   logic [lrbc_pkg::DIST_W-1:0]         ring0_in, ring0_ff;
   logic [LANES-1:0]                    hit_in, hit_ff;
   logic [lrbc_pkg::LEVEL_W-1:0]        n_in, n_ff;
   logic [lrbc_pkg::LEVEL_W-1:0]        level_in, rsp_level_ff;
   logic [R2_W-1:0]                     dist_wide;
   logic [R2_W-1:0]                     ring_sq [LANES];

   // config port
   always_ff @(posedge clock) begin
      if (reset) begin
         focus_ff[0]    <= '0;
         focus_ff[1]    <= '0;
         focus_ff[2]    <= '0;
         voxel_size_ff  <= lrbc_pkg::VOXEL_SIZE_RESET;
         level_count_ff <= lrbc_pkg::LEVEL_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            lrbc_pkg::CSR_FOCUS_X:     focus_ff[0]    <= csr_data;
            lrbc_pkg::CSR_FOCUS_Y:     focus_ff[1]    <= csr_data;
            lrbc_pkg::CSR_FOCUS_Z:     focus_ff[2]    <= csr_data;
            lrbc_pkg::CSR_VOXEL_SIZE:  voxel_size_ff  <= csr_data[lrbc_pkg::SIZE_W-1:0];
            lrbc_pkg::CSR_LEVEL_COUNT: level_count_ff <= csr_data[lrbc_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !v6_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 1: cube bounds
   assign center[0] = req_center_x;
   assign center[1] = req_center_y;
   assign center[2] = req_center_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_in[a] = lrbc_pkg::bound_type'(center[a])
                  - $signed({3'b000, req_half_size});
         hi_in[a] = lrbc_pkg::bound_type'(center[a])
                  + $signed({3'b000, req_half_size});
      end
   end

   // stage 2: clamp focus onto cube, distance per axis
   always_comb begin
      lrbc_pkg::bound_type f;
      lrbc_pkg::bound_type d_lo;
      lrbc_pkg::bound_type d_hi;
      for (int a = 0; a < 3; a++) begin
         f    = lrbc_pkg::bound_type'(focus_ff[a]);
         d_lo = lo_ff[a] - f;
         d_hi = f - hi_ff[a];
         if (f < lo_ff[a]) begin
            gap_in[a] = d_lo[lrbc_pkg::GAP_W-1:0];
         end else if (f > hi_ff[a]) begin
            gap_in[a] = d_hi[lrbc_pkg::GAP_W-1:0];
         end else begin
            gap_in[a] = '0;
         end
      end
   end

   // stage 4: squared distance and innermost ring radius squared (9 v^2)
   assign dist_in  = lrbc_pkg::DIST_W'(sq_ff[0]) + lrbc_pkg::DIST_W'(sq_ff[1])
                   + lrbc_pkg::DIST_W'(sq_ff[2]);
   assign ring0_in = (lrbc_pkg::DIST_W'(vsq_ff) << 3) + lrbc_pkg::DIST_W'(vsq_ff);

   // stage 5: ring compares, last ring has zero radius
   assign n_in      = (int'(level_count_ff) > LANES) ? lrbc_pkg::LEVEL_W'(LANES)
                                                     : level_count_ff;
   assign dist_wide = R2_W'(dist_ff);

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         ring_sq[i] = R2_W'(ring0_ff) << (2 * i);
         if (i >= int'(n_in)) begin
            hit_in[i] = 1'b0;
         end else if (i + 1 < int'(n_in)) begin
            hit_in[i] = dist_wide <= ring_sq[i];
         end else begin
            hit_in[i] = dist_ff == '0;
         end
      end
   end

   // stage 6: first ring hit
   always_comb begin
      level_in = n_ff;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            level_in = lrbc_pkg::LEVEL_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            lo_ff[a]  <= lo_in[a];
            hi_ff[a]  <= hi_in[a];
            gap_ff[a] <= gap_in[a];
            sq_ff[a]  <= gap_ff[a] * gap_ff[a];
         end
         vsq_ff       <= voxel_size_ff * voxel_size_ff;
         dist_ff      <= dist_in;
         ring0_ff     <= ring0_in;
         hit_ff       <= hit_in;
         n_ff         <= n_in;
         rsp_level_ff <= level_in;
      end
   end

   assign rsp_valid = v6_ff;
   assign rsp_level = rsp_level_ff;

   // level never exceeds the clamped ring count
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> (rsp_level_ff <= n_in))
      else $error("level above ring count");

   // an accepted word reaches the output when every stage moves with no reset between
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && !req_stall, 6) && $past(advance, 5) && $past(advance, 4)
       && $past(advance, 3) && $past(advance, 2) && $past(advance, 1)
       && !$past(reset, 5) && !$past(reset, 4) && !$past(reset, 3)
       && !$past(reset, 2) && !$past(reset, 1) && !$past(reset, 6))
      |-> rsp_valid)
      else $error("word lost in pipeline");

endmodule

// ===== sim/lrbc_ring_checker.sv =====
`timescale 1ns / 100ps

module lrbc_ring_checker #(
   parameter int RING_LIMIT = 15
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            csr_write,
   input  logic [lrbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lrbc_pkg::CSR_DATA_W-1:0] csr_data,

   input  logic                            req_valid,
   input  logic                            req_stall,
   input  lrbc_pkg::coord_type             req_center_x,
   input  lrbc_pkg::coord_type             req_center_y,
   input  lrbc_pkg::coord_type             req_center_z,
   input  logic [lrbc_pkg::SIZE_W-1:0]     req_half_size,

   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [lrbc_pkg::LEVEL_W-1:0]    rsp_level,

   output int                              fail_count,
   output int                              pending
);

   lrbc_pkg::coord_type            focus_x;
   lrbc_pkg::coord_type            focus_y;
   lrbc_pkg::coord_type            focus_z;
   logic [lrbc_pkg::SIZE_W-1:0]    voxel_size;
   logic [lrbc_pkg::LEVEL_W-1:0]   level_count;

   logic [lrbc_pkg::LEVEL_W-1:0]   level_queue[$];
   logic [lrbc_pkg::LEVEL_W-1:0]   want_level;

   task automatic report_mismatch(input string note);
      $display("[ring check] mismatch at %0t: %s", $time, note);
      fail_count++;
   endtask

   // squared distance on one axis from the focus to its clamp into the cube
   function automatic logic [127:0] gap_square(input lrbc_pkg::coord_type f,
                                               input lrbc_pkg::coord_type c,
                                               input logic [lrbc_pkg::SIZE_W-1:0] h);
      longint lo;
      longint hi;
      longint near;
      longint d;
      lo   = longint'(c) - longint'(h);
      hi   = longint'(c) + longint'(h);
      near = longint'(f);
      if (longint'(f) < lo) begin
         near = lo;
      end else if (longint'(f) > hi) begin
         near = hi;
      end
      d = near - longint'(f);
      if (d < 0) begin
         d = -d;
      end
      return 128'(d) * 128'(d);
   endfunction

   function automatic logic [lrbc_pkg::LEVEL_W-1:0] ring_level(
         input lrbc_pkg::coord_type cx, input lrbc_pkg::coord_type cy,
         input lrbc_pkg::coord_type cz, input logic [lrbc_pkg::SIZE_W-1:0] hs);
      logic [127:0] dist2;
      logic [127:0] radius;
      int           rings;
      int           lvl;
      dist2 = gap_square(focus_x, cx, hs) + gap_square(focus_y, cy, hs)
            + gap_square(focus_z, cz, hs);
      rings = (int'(level_count) > RING_LIMIT) ? RING_LIMIT : int'(level_count);
      lvl   = rings;
      for (int i = 0; i < rings; i++) begin
         // last ring has zero radius
         radius = (i + 1 < rings) ? ((128'(voxel_size) * 128'd3) << i) : 128'd0;
         if (dist2 <= radius * radius) begin
            lvl = i;
            break;
         end
      end
      return lrbc_pkg::LEVEL_W'(lvl);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         focus_x     = '0;
         focus_y     = '0;
         focus_z     = '0;
         voxel_size  = lrbc_pkg::VOXEL_SIZE_RESET;
         level_count = lrbc_pkg::LEVEL_COUNT_RESET;
         level_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (level_queue.size() == 0) begin
               report_mismatch($sformatf("level %0d with no word pending", rsp_level));
            end else begin
               want_level = level_queue.pop_front();
               if (rsp_level !== want_level) begin
                  report_mismatch($sformatf("level %0d, predicted %0d", rsp_level,
                                            want_level));
               end
            end
         end
         if (req_valid && !req_stall) begin
            level_queue = {level_queue, ring_level(req_center_x, req_center_y,
                                                   req_center_z, req_half_size)};
         end
         if (csr_write) begin
            case (csr_index)
               lrbc_pkg::CSR_FOCUS_X:     focus_x = lrbc_pkg::coord_type'(csr_data);
               lrbc_pkg::CSR_FOCUS_Y:     focus_y = lrbc_pkg::coord_type'(csr_data);
               lrbc_pkg::CSR_FOCUS_Z:     focus_z = lrbc_pkg::coord_type'(csr_data);
               lrbc_pkg::CSR_VOXEL_SIZE:  voxel_size = csr_data[lrbc_pkg::SIZE_W-1:0];
               lrbc_pkg::CSR_LEVEL_COUNT: level_count = csr_data[lrbc_pkg::LEVEL_W-1:0];
               default: ;
            endcase
         end
      end
      pending = level_queue.size();
   end

endmodule

// ===== sim/lod_ring_box_classifier_test.sv =====
`timescale 1ns / 100ps

module lod_ring_box_classifier_test;

   localparam int RING_LIMIT  = 15;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SEGMENTS    = 9;
   localparam int SEG_WORDS   = 204;

   localparam lrbc_pkg::coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam lrbc_pkg::coord_type COORD_MIN = 32'sh8000_0000;
   localparam logic [lrbc_pkg::SIZE_W-1:0] SIZE_MAX  = 31'h7FFF_FFFF;
   localparam logic [lrbc_pkg::SIZE_W-1:0] SIZE_ZERO = 31'd0;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;

   logic                            csr_write = 1'b0;
   logic [lrbc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [lrbc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic                            req_valid = 1'b0;
   logic                            req_stall;
   lrbc_pkg::coord_type             req_center_x = '0;
   lrbc_pkg::coord_type             req_center_y = '0;
   lrbc_pkg::coord_type             req_center_z = '0;
   logic [lrbc_pkg::SIZE_W-1:0]     req_half_size = '0;

   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [lrbc_pkg::LEVEL_W-1:0]    rsp_level;

   int                              fail_count;
   int                              pending;

   int                              send_idle_pct = 37;
   int                              stall_pct = 66;
   int                              cycle_count = 0;

   lrbc_pkg::coord_type             cur_fx = '0;
   lrbc_pkg::coord_type             cur_fy = '0;
   lrbc_pkg::coord_type             cur_fz = '0;
   logic [lrbc_pkg::SIZE_W-1:0]     cur_vs = lrbc_pkg::VOXEL_SIZE_RESET;
   logic [lrbc_pkg::LEVEL_W-1:0]    cur_lc = lrbc_pkg::LEVEL_COUNT_RESET;

   lod_ring_box_classifier #(.LEVEL_LIMIT(RING_LIMIT)) i_dut (.*);

   lrbc_ring_checker #(.RING_LIMIT(RING_LIMIT)) i_check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[lod_ring_box_classifier] ERROR");
         $finish;
      end
   end

   function automatic longint near_offset();
      return longint'($signed($urandom)) >>> $urandom_range(31);
   endfunction

   function automatic logic [lrbc_pkg::SIZE_W-1:0] rand_size();
      return lrbc_pkg::SIZE_W'($urandom >> $urandom_range(32, 1));
   endfunction

   task automatic send_cube(input lrbc_pkg::coord_type cx, input lrbc_pkg::coord_type cy,
                            input lrbc_pkg::coord_type cz,
                            input logic [lrbc_pkg::SIZE_W-1:0] hs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_center_x  <= cx;
      req_center_y  <= cy;
      req_center_z  <= cz;
      req_half_size <= hs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [lrbc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lrbc_pkg::CSR_DATA_W-1:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
   endtask

   task automatic load_config(input lrbc_pkg::coord_type fx, input lrbc_pkg::coord_type fy,
                              input lrbc_pkg::coord_type fz,
                              input logic [lrbc_pkg::SIZE_W-1:0] vs,
                              input logic [lrbc_pkg::LEVEL_W-1:0] lc);
      drain();
      write_reg(lrbc_pkg::CSR_FOCUS_X, fx);
      write_reg(lrbc_pkg::CSR_FOCUS_Y, fy);
      write_reg(lrbc_pkg::CSR_FOCUS_Z, fz);
      write_reg(lrbc_pkg::CSR_VOXEL_SIZE, lrbc_pkg::CSR_DATA_W'(vs));
      write_reg(lrbc_pkg::CSR_LEVEL_COUNT, lrbc_pkg::CSR_DATA_W'(lc));
      csr_write <= 1'b0;
      cur_fx = fx;
      cur_fy = fy;
      cur_fz = fz;
      cur_vs = vs;
      cur_lc = lc;
   endtask

   task automatic random_cube();
      lrbc_pkg::coord_type         cx;
      lrbc_pkg::coord_type         cy;
      lrbc_pkg::coord_type         cz;
      logic [lrbc_pkg::SIZE_W-1:0] hs;
      longint                      r;
      case ($urandom_range(9)) inside
         [0:1]: begin
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
            hs = lrbc_pkg::SIZE_W'($urandom);
         end
         [2:4]: begin
            // x gap lands within a couple of LSBs of a ring radius
            hs = rand_size();
            r  = (longint'(cur_vs) * 3) << $urandom_range(cur_lc > 1 ? cur_lc - 2 : 0);
            r  = r + longint'($urandom_range(4)) - 2;
            if ($urandom_range(1)) begin
               cx = lrbc_pkg::coord_type'(longint'(cur_fx) + longint'(hs) + r);
            end else begin
               cx = lrbc_pkg::coord_type'(longint'(cur_fx) - longint'(hs) - r);
            end
            cy = ($urandom_range(1)) ? cur_fy
                                     : lrbc_pkg::coord_type'(longint'(cur_fy) + near_offset());
            cz = cur_fz;
         end
         default: begin
            cx = lrbc_pkg::coord_type'(longint'(cur_fx) + near_offset());
            cy = lrbc_pkg::coord_type'(longint'(cur_fy) + near_offset());
            cz = lrbc_pkg::coord_type'(longint'(cur_fz) + near_offset());
            hs = rand_size();
         end
      endcase
      send_cube(cx, cy, cz, hs);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset config: ring 0 radius 19200, ring 6 radius 1228800, 8 rings
      send_cube(0, 0, 0, SIZE_ZERO);
      send_cube(19200, 0, 0, SIZE_ZERO);
      send_cube(19201, 0, 0, SIZE_ZERO);
      send_cube(0, -38400, 0, SIZE_ZERO);
      send_cube(0, 0, 38401, SIZE_ZERO);
      send_cube(1228800, 0, 0, SIZE_ZERO);
      send_cube(-1228801, 0, 0, SIZE_ZERO);
      send_cube(20000, 0, 0, 31'd800);
      send_cube(11085, -11085, 11085, SIZE_ZERO);
      send_cube(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_ZERO);
      send_cube(COORD_MIN, COORD_MIN, COORD_MIN, SIZE_ZERO);
      send_cube(COORD_MIN, COORD_MAX, COORD_MIN, SIZE_MAX);
      send_cube(COORD_MAX, 0, 0, SIZE_MAX);

      load_config(COORD_MAX, COORD_MIN, COORD_MAX, SIZE_MAX, 4'd15);
      send_cube(COORD_MIN, COORD_MAX, COORD_MIN, SIZE_ZERO);
      send_cube(COORD_MAX, COORD_MIN, COORD_MAX, SIZE_ZERO);
      send_cube(COORD_MIN, COORD_MAX, COORD_MIN, SIZE_MAX);
      send_cube(0, 0, 0, SIZE_MAX);
      send_cube(-1, 0, -1, SIZE_MAX);
      send_cube(COORD_MIN, COORD_MIN, COORD_MIN, 31'h0000_0001);

      load_config(COORD_MIN, COORD_MAX, COORD_MIN, 31'd0, 4'd0);
      send_cube(COORD_MIN, COORD_MAX, COORD_MIN, SIZE_ZERO);
      send_cube(COORD_MAX, COORD_MIN, COORD_MAX, SIZE_MAX);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: load_config(lrbc_pkg::coord_type'(near_offset()),
                           lrbc_pkg::coord_type'(near_offset()),
                           lrbc_pkg::coord_type'(near_offset()),
                           lrbc_pkg::VOXEL_SIZE_RESET, lrbc_pkg::LEVEL_COUNT_RESET);
            1: load_config($urandom, $urandom, $urandom, SIZE_MAX, 4'd15);
            2: load_config(lrbc_pkg::coord_type'(near_offset()), $urandom,
                           lrbc_pkg::coord_type'(near_offset()),
                           31'd0, lrbc_pkg::LEVEL_W'($urandom_range(15, 1)));
            3: load_config($urandom, lrbc_pkg::coord_type'(near_offset()), $urandom,
                           rand_size(), 4'd0);
            4: load_config(lrbc_pkg::coord_type'(near_offset()),
                           lrbc_pkg::coord_type'(near_offset()),
                           lrbc_pkg::coord_type'(near_offset()), rand_size(), 4'd1);
            5: load_config(COORD_MIN, COORD_MAX, COORD_MIN, rand_size(), 4'd15);
            default: load_config(lrbc_pkg::coord_type'(near_offset()),
                                 lrbc_pkg::coord_type'(near_offset()),
                                 $urandom, rand_size(),
                                 lrbc_pkg::LEVEL_W'($urandom_range(15)));
         endcase
         if (seg < 3) begin
            send_idle_pct = 37;
            stall_pct     = 66;
         end else if (seg < 6) begin
            send_idle_pct = 66;
            stall_pct     = 37;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         repeat (SEG_WORDS) random_cube();
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[lod_ring_box_classifier] OK");
      end else begin
         $display("[lod_ring_box_classifier] ERROR");
      end
      $finish;
   end

endmodule
